// ----- sv/mmrc_pkg.sv -----
package mmrc_pkg;

    // Field widths fixed by the interface
    localparam int OP_W         = 2;
    localparam int TYPE_W       = 5;
    localparam int ADDR_W       = 64;
    localparam int READ_IDX_W   = 4;
    localparam int ACTION_W     = 3;
    localparam int RC_W         = 5;
    localparam int MASK_W       = 32;

    // Page to byte conversion
    localparam int PAGE_SHIFT   = 12;

    // Defaults
    localparam int MAX_REGIONS_DEF = 16;
    localparam logic [MASK_W-1:0] TYPE_MASK_RST = 32'd158;

    // Operation codes
    localparam logic [OP_W-1:0] OP_DESC  = 2'd0;
    localparam logic [OP_W-1:0] OP_READ  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    // Action codes
    localparam logic [ACTION_W-1:0] ACT_DROP   = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_MERGE  = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_APPEND = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_FULL   = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_READ   = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_CLEAR  = 3'd5;

    // Sequencer to datapath commands
    typedef struct packed {
        logic load;   // capture the input word
        logic exec;   // evaluate, update table, launch read
        logic emit;   // result word on the outputs
    } t_dp_cmd;

endpackage

// ----- sv/mmrc_ctrl.sv -----
module mmrc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    output mmrc_pkg::t_dp_cmd o_cmd
);
    import mmrc_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) n_state = S_EXEC;
            end
            S_EXEC: n_state = S_DONE;
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Commands
    assign busy       = (r_state != S_IDLE);
    assign o_cmd.load = (r_state == S_IDLE) && start;
    assign o_cmd.exec = (r_state == S_EXEC);
    assign o_cmd.emit = (r_state == S_DONE);

endmodule

// ----- sv/mmrc_dp.sv -----
module mmrc_dp #(
    parameter int MAX_REGIONS = mmrc_pkg::MAX_REGIONS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  mmrc_pkg::t_dp_cmd                   i_cmd,
    input  logic [mmrc_pkg::OP_W-1:0]           i_op,
    input  logic [mmrc_pkg::TYPE_W-1:0]         i_mem_type,
    input  logic [mmrc_pkg::ADDR_W-1:0]         i_base_addr,
    input  logic [mmrc_pkg::ADDR_W-1:0]         i_page_count,
    input  logic [mmrc_pkg::READ_IDX_W-1:0]     i_read_index,
    input  logic                                i_cfg_we,
    input  logic [mmrc_pkg::MASK_W-1:0]         i_cfg_data,
    output logic [mmrc_pkg::ACTION_W-1:0]       o_action,
    output logic [mmrc_pkg::RC_W-1:0]           o_region_count,
    output logic [mmrc_pkg::ADDR_W-1:0]         o_entry_base,
    output logic [mmrc_pkg::ADDR_W-1:0]         o_entry_size
);
    import mmrc_pkg::*;

    localparam int CW   = $clog2(MAX_REGIONS + 1);
    localparam int IW   = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam int CMPW = (CW > READ_IDX_W) ? CW : READ_IDX_W;

    // Captured input word
    logic [OP_W-1:0]       r_op;
    logic [TYPE_W-1:0]     r_mem_type;
    logic [ADDR_W-1:0]     r_base;
    logic [ADDR_W-1:0]     r_size;
    logic [READ_IDX_W-1:0] r_idx;

    // Table state
    logic [MASK_W-1:0]     r_type_mask;
    logic [CW-1:0]         r_count;
    logic [CW-1:0]         n_count;
    logic [ADDR_W-1:0]     r_last_base;
    logic [ADDR_W-1:0]     r_last_size;
    logic [ADDR_W-1:0]     mem_base [MAX_REGIONS];
    logic [ADDR_W-1:0]     mem_size [MAX_REGIONS];

    // Result registers
    logic [ACTION_W-1:0]   r_action;
    logic [ACTION_W-1:0]   n_action;
    logic                  r_rd_ok;
    logic [ADDR_W-1:0]     r_rd_base;
    logic [ADDR_W-1:0]     r_rd_size;

    logic                  full;
    logic                  type_ok;
    logic                  merge_hit;
    logic [ADDR_W-1:0]     merged_size;
    logic                  wr_app;
    logic                  wr_mrg;
    logic                  rd_ok;
    logic [IW-1:0]         app_addr;
    logic [IW-1:0]         last_addr;
    logic [IW-1:0]         rd_addr;
    logic [IW-1:0]         sz_addr;
    logic [ADDR_W-1:0]     sz_data;
    logic [CMPW-1:0]       idx_ext;
    logic [CMPW-1:0]       cnt_ext;

    // Capture the word; size wraps at 64 bits
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op       <= i_op;
            r_mem_type <= i_mem_type;
            r_base     <= i_base_addr;
            r_size     <= i_page_count << PAGE_SHIFT;
            r_idx      <= i_read_index;
        end
    end

    // Type mask register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_type_mask <= TYPE_MASK_RST;
        end else if (i_cfg_we) begin
            r_type_mask <= i_cfg_data;
        end
    end

    // Decision logic
    assign full        = (r_count == CW'(MAX_REGIONS));
    assign type_ok     = r_type_mask[r_mem_type];
    assign merge_hit   = (r_count != '0) && ((r_last_base + r_last_size) == r_base);
    assign merged_size = r_last_size + r_size;
    assign idx_ext     = CMPW'(r_idx);
    assign cnt_ext     = CMPW'(r_count);
    assign app_addr    = IW'(r_count);
    assign last_addr   = IW'(r_count - CW'(1));
    assign rd_addr     = IW'(r_idx);

    always_comb begin
        n_action = ACT_DROP;
        n_count  = r_count;
        wr_app   = 1'b0;
        wr_mrg   = 1'b0;
        rd_ok    = 1'b0;
        unique case (r_op)
            OP_DESC: begin
                if (full) begin
                    n_action = ACT_FULL;
                end else if (!type_ok || (r_size == '0)) begin
                    n_action = ACT_DROP;
                end else if (merge_hit) begin
                    n_action = ACT_MERGE;
                    wr_mrg   = 1'b1;
                end else begin
                    n_action = ACT_APPEND;
                    wr_app   = 1'b1;
                    n_count  = r_count + CW'(1);
                end
            end
            OP_READ: begin
                n_action = ACT_READ;
                rd_ok    = (idx_ext < cnt_ext) && (idx_ext < CMPW'(MAX_REGIONS));
            end
            OP_CLEAR: begin
                n_action = ACT_CLEAR;
                n_count  = '0;
            end
            default: n_action = ACT_DROP;
        endcase
    end

    // Size array has one write port shared by merge and append
    assign sz_addr = wr_mrg ? last_addr : app_addr;
    assign sz_data = wr_mrg ? merged_size : r_size;

    // Region table memories
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && wr_app) begin
            mem_base[app_addr] <= r_base;
        end
        if (i_cmd.exec && (wr_app || wr_mrg)) begin
            mem_size[sz_addr] <= sz_data;
        end
        if (i_cmd.exec && rd_ok) begin
            r_rd_base <= mem_base[rd_addr];
            r_rd_size <= mem_size[rd_addr];
        end
    end

    // Count and last-region shadow
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.exec) begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && wr_app) begin
            r_last_base <= r_base;
            r_last_size <= r_size;
        end else if (i_cmd.exec && wr_mrg) begin
            r_last_size <= merged_size;
        end
    end

    // Result word
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_action <= n_action;
            r_rd_ok  <= rd_ok;
        end
    end

    assign o_action       = r_action;
    assign o_region_count = RC_W'(r_count);
    assign o_entry_base   = r_rd_ok ? r_rd_base : '0;
    assign o_entry_size   = r_rd_ok ? r_rd_size : '0;

endmodule

// ----- sv/memory_map_region_coalescer_unit.sv -----
// Channel   | Ports                                              | Handshake
// ----------+----------------------------------------------------+---------------------------
// command   | i_op i_mem_type i_base_addr i_page_count i_read_index | start & !busy
// result    | o_action o_region_count o_entry_base o_entry_size  | o_result_strobe, 1 cycle
// config    | i_cfg_data (type mask)                             | i_cfg_valid & o_cfg_ready
//
// Each word passes through three steps: capture, evaluate/update, present. The result strobe
// fires in S_DONE, which follows the S_EXEC state after the accepting edge, and busy drops the cycle after.
// The step sequence is set by the three-step sequencer and the registered table read.
// Reset (synchronous, low) clears the region count and restores the type mask
// to 158; table contents stay undefined until written.
// The result side cannot stall; each result is valid for its strobe cycle only.
module memory_map_region_coalescer_unit #(
    parameter int MAX_REGIONS = mmrc_pkg::MAX_REGIONS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [mmrc_pkg::OP_W-1:0]           i_op,
    input  logic [mmrc_pkg::TYPE_W-1:0]         i_mem_type,
    input  logic [mmrc_pkg::ADDR_W-1:0]         i_base_addr,
    input  logic [mmrc_pkg::ADDR_W-1:0]         i_page_count,
    input  logic [mmrc_pkg::READ_IDX_W-1:0]     i_read_index,
    output logic                                o_result_strobe,
    output logic [mmrc_pkg::ACTION_W-1:0]       o_action,
    output logic [mmrc_pkg::RC_W-1:0]           o_region_count,
    output logic [mmrc_pkg::ADDR_W-1:0]         o_entry_base,
    output logic [mmrc_pkg::ADDR_W-1:0]         o_entry_size,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [mmrc_pkg::MASK_W-1:0]         i_cfg_data
);
    import mmrc_pkg::*;

    t_dp_cmd cmd;

    // Mask register takes a write at any time
    assign o_cfg_ready = 1'b1;

    mmrc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_cmd   (cmd)
    );

    mmrc_dp #(
        .MAX_REGIONS (MAX_REGIONS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_op           (i_op),
        .i_mem_type     (i_mem_type),
        .i_base_addr    (i_base_addr),
        .i_page_count   (i_page_count),
        .i_read_index   (i_read_index),
        .i_cfg_we       (i_cfg_valid && o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .o_action       (o_action),
        .o_region_count (o_region_count),
        .o_entry_base   (o_entry_base),
        .o_entry_size   (o_entry_size)
    );

    assign o_result_strobe = cmd.emit;

    // Accepted word yields its result strobe in S_DONE, after S_EXEC
    a_result_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> ##1 o_result_strobe)
        else $error("result strobe missing after accepted word");

    // Strobe only while a word is in flight
    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |-> busy)
        else $error("result strobe while idle");

    // Entry fields are zero for anything but a read
    a_entry_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_strobe && (o_action != ACT_READ)) |->
        ((o_entry_base == '0) && (o_entry_size == '0)))
        else $error("entry data on a non-read result");

    // A clear leaves the table empty
    a_clear_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_strobe && (o_action == ACT_CLEAR)) |-> (o_region_count == '0))
        else $error("count not zero after clear");

endmodule

// ----- tb/sv/tb_memory_map_region_coalescer_unit.sv -----
`timescale 1ns / 1ps

module tb_memory_map_region_coalescer_unit;
    import mmrc_pkg::*;

    localparam int MAX_REGIONS = MAX_REGIONS_DEF;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int STALL_LIMIT = 2000;
    localparam int N_PHASES = 7;

    // One result word as the block reports it
    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [RC_W-1:0]     region_count;
        logic [ADDR_W-1:0]   entry_base;
        logic [ADDR_W-1:0]   entry_size;
    } outcome_t;

    // Shadow region list plus queue of outcomes still owed by the block
    class region_table_tracker;
        logic [MASK_W-1:0] type_mask;
        logic [ADDR_W-1:0] bases [MAX_REGIONS];
        logic [ADDR_W-1:0] sizes [MAX_REGIONS];
        int unsigned       count;
        outcome_t          owed_outcomes[$];
        int                errors;
        int                words_seen;
        int                hits [8];

        function new();
            type_mask  = TYPE_MASK_RST;
            count      = 0;
            errors     = 0;
            words_seen = 0;
            foreach (hits[i]) hits[i] = 0;
        endfunction

        // End address of the last stored region, wrapping at 2^64
        function logic [ADDR_W-1:0] tail_end();
            if (count == 0) return '0;
            return bases[count-1] + sizes[count-1];
        endfunction

        // Coalesce one accepted command word into the shadow list
        function void note_command(input logic [OP_W-1:0] op, input logic [TYPE_W-1:0] mtype,
                                   input logic [ADDR_W-1:0] base, input logic [ADDR_W-1:0] pages,
                                   input logic [READ_IDX_W-1:0] idx);
            outcome_t         o;
            logic [ADDR_W-1:0] bytes;
            o = '0;
            o.action = ACT_DROP;
            bytes = pages << PAGE_SHIFT;
            case (op)
                OP_DESC: begin
                    if (count >= MAX_REGIONS) begin
                        o.action = ACT_FULL;
                    end else if (!type_mask[mtype]) begin
                        o.action = ACT_DROP;
                    end else if (bytes == '0) begin
                        o.action = ACT_DROP;
                    end else if (count > 0 && tail_end() == base) begin
                        sizes[count-1] += bytes;
                        o.action = ACT_MERGE;
                    end else begin
                        bases[count] = base;
                        sizes[count] = bytes;
                        count++;
                        o.action = ACT_APPEND;
                    end
                end
                OP_READ: begin
                    o.action = ACT_READ;
                    if (idx < count) begin
                        o.entry_base = bases[idx];
                        o.entry_size = sizes[idx];
                    end
                end
                OP_CLEAR: begin
                    count = 0;
                    o.action = ACT_CLEAR;
                end
                default: ;
            endcase
            o.region_count = count[RC_W-1:0];
            owed_outcomes.push_back(o);
            words_seen++;
        endfunction

        // Compare a result word against the oldest owed outcome
        function void check_outcome(input outcome_t got);
            outcome_t want;
            if (owed_outcomes.size() == 0) begin
                $error("result word with nothing outstanding: action %0d", got.action);
                errors++;
                return;
            end
            want = owed_outcomes.pop_front();
            hits[got.action]++;
            if (got.action !== want.action) begin
                $error("action: expected %0d, got %0d", want.action, got.action);
                errors++;
            end
            if (got.region_count !== want.region_count) begin
                $error("region_count: expected %0d, got %0d", want.region_count,
                       got.region_count);
                errors++;
            end
            if (got.entry_base !== want.entry_base) begin
                $error("entry_base: expected %h, got %h", want.entry_base, got.entry_base);
                errors++;
            end
            if (got.entry_size !== want.entry_size) begin
                $error("entry_size: expected %h, got %h", want.entry_size, got.entry_size);
                errors++;
            end
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic [OP_W-1:0]       i_op = '0;
    logic [TYPE_W-1:0]     i_mem_type = '0;
    logic [ADDR_W-1:0]     i_base_addr = '0;
    logic [ADDR_W-1:0]     i_page_count = '0;
    logic [READ_IDX_W-1:0] i_read_index = '0;
    logic                  o_result_strobe;
    logic [ACTION_W-1:0]   o_action;
    logic [RC_W-1:0]       o_region_count;
    logic [ADDR_W-1:0]     o_entry_base;
    logic [ADDR_W-1:0]     o_entry_size;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [MASK_W-1:0]     i_cfg_data = '0;

    region_table_tracker sb;
    int                  idle_cycles = 0;
    int                  mask_writes = 0;
    bit                  steady = 1'b0;

    memory_map_region_coalescer_unit #(.MAX_REGIONS(MAX_REGIONS)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_op(i_op), .i_mem_type(i_mem_type), .i_base_addr(i_base_addr),
        .i_page_count(i_page_count), .i_read_index(i_read_index),
        .o_result_strobe(o_result_strobe), .o_action(o_action),
        .o_region_count(o_region_count), .o_entry_base(o_entry_base),
        .o_entry_size(o_entry_size), .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Result side: every strobe is a word that must match
    always @(posedge i_clk) begin
        if (i_rst_n && o_result_strobe) begin
            sb.check_outcome(outcome_t'{o_action, o_region_count, o_entry_base, o_entry_size});
        end
    end

    // Watchdog on cycles with no handshake of any kind
    always @(posedge i_clk) begin
        if ((start && !busy) || o_result_strobe || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic logic [ADDR_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Mostly small page counts, some huge, a few zero
    function automatic logic [ADDR_W-1:0] rand_pages();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return ADDR_W'($urandom_range(1, 64));
        if (r < 85) return ADDR_W'($urandom_range(1, 1 << 20));
        if (r < 95) return rand64();
        return '0;
    endfunction

    // A type the current mask keeps, when there is one
    function automatic logic [TYPE_W-1:0] kept_type();
        int kept[$];
        for (int t = 0; t < 32; t++) begin
            if (sb.type_mask[t]) kept.push_back(t);
        end
        if (kept.size() == 0) return TYPE_W'($urandom_range(0, 31));
        return TYPE_W'(kept[$urandom_range(0, kept.size() - 1)]);
    endfunction

    function automatic int pick_gap();
        int r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Present one command word and hold it until the block takes it
    task automatic send_word(input logic [OP_W-1:0] op, input logic [TYPE_W-1:0] mtype,
                             input logic [ADDR_W-1:0] base, input logic [ADDR_W-1:0] pages,
                             input logic [READ_IDX_W-1:0] idx);
        int gap;
        i_op         <= op;
        i_mem_type   <= mtype;
        i_base_addr  <= base;
        i_page_count <= pages;
        i_read_index <= idx;
        start        <= 1'b1;
        do @(posedge i_clk); while (busy);
        sb.note_command(op, mtype, base, pages, idx);
        gap = pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Let every owed result come back and the block go quiet
    task automatic drain();
        start <= 1'b0;
        while (sb.owed_outcomes.size() != 0 || busy) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_type_mask(input logic [MASK_W-1:0] m);
        i_cfg_data  <= m;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        sb.type_mask = m;
        mask_writes++;
    endtask

    // Random word: mostly chains that merge or append, some reads, clears and noise
    task automatic send_random_word();
        int r;
        logic [READ_IDX_W-1:0] idx;
        r = $urandom_range(0, 99);
        if (sb.count >= MAX_REGIONS && $urandom_range(0, 7) == 0) begin
            send_word(OP_CLEAR, TYPE_W'($urandom), rand64(), rand64(), READ_IDX_W'($urandom));
        end else if (r < 40) begin
            send_word(OP_DESC, kept_type(), sb.count > 0 ? sb.tail_end() : rand64(),
                      rand_pages(), READ_IDX_W'($urandom));
        end else if (r < 65) begin
            send_word(OP_DESC, kept_type(), rand64(), rand_pages(), READ_IDX_W'($urandom));
        end else if (r < 80) begin
            if (sb.count > 0 && $urandom_range(0, 4) != 0) begin
                idx = READ_IDX_W'($urandom_range(0, sb.count - 1));
            end else begin
                idx = READ_IDX_W'($urandom);
            end
            send_word(OP_READ, TYPE_W'($urandom), rand64(), rand64(), idx);
        end else if (r < 82) begin
            send_word(OP_CLEAR, TYPE_W'($urandom), rand64(), rand64(), READ_IDX_W'($urandom));
        end else if (r < 85) begin
            send_word(OP_UNUSED, TYPE_W'($urandom), rand64(), rand64(), READ_IDX_W'($urandom));
        end else begin
            send_word(OP_DESC, TYPE_W'($urandom), rand64(), rand_pages(),
                      READ_IDX_W'($urandom));
        end
    endtask

    initial begin
        logic [MASK_W-1:0] mask_plan [N_PHASES];
        int                word_plan [N_PHASES];
        sb = new();
        mask_plan = '{32'hFFFF_FFFF, 32'h0000_0000, $urandom, 32'h8000_0001,
                      TYPE_MASK_RST, $urandom, 32'hFFFF_FFFF};
        word_plan = '{400, 80, 350, 250, 300, 300, 250};

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty read, unused op, type filter, wrap at 2^64, zero size
        send_word(OP_READ, '0, '0, '0, 4'hF);
        send_word(OP_UNUSED, 5'h1F, '1, '1, 4'hF);
        send_word(OP_DESC, 5'd0, 64'h1000, 64'd1, 4'h0);
        send_word(OP_DESC, 5'd1, 64'hFFFF_FFFF_FFFF_F000, 64'd1, 4'h0);
        send_word(OP_DESC, 5'd2, 64'h0, '1, 4'h0);
        send_word(OP_DESC, 5'd3, 64'h5000, 64'hFFF0_0000_0000_0000, 4'h0);
        send_word(OP_DESC, 5'd7, 64'h9000, 64'd0, 4'h0);
        send_word(OP_READ, '0, '0, '0, 4'h0);
        send_word(OP_CLEAR, '0, '0, '0, 4'h0);
        // Fill the list with disjoint regions, then hit it while full
        for (int i = 0; i < MAX_REGIONS; i++) begin
            send_word(OP_DESC, 5'd4, 64'(i + 1) << 32, 64'(i + 1), 4'h0);
        end
        send_word(OP_DESC, 5'd4, sb.tail_end(), 64'd1, 4'h0);
        send_word(OP_READ, '0, '0, '0, 4'hF);

        // Random phases, one type mask each
        for (int p = 0; p < N_PHASES; p++) begin
            drain();
            write_type_mask(mask_plan[p]);
            for (int k = 0; k < word_plan[p]; k++) begin
                if (k % 64 == 0) steady = ($urandom_range(0, 3) == 0);
                send_random_word();
            end
        end

        start <= 1'b0;
        while (sb.owed_outcomes.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Ran %0d command words over %0d type mask settings.",
                 sb.words_seen, mask_writes);
        $display("Seen: %0d appends, %0d merges, %0d full, %0d drops, %0d reads, %0d clears.",
                 sb.hits[ACT_APPEND], sb.hits[ACT_MERGE], sb.hits[ACT_FULL],
                 sb.hits[ACT_DROP], sb.hits[ACT_READ], sb.hits[ACT_CLEAR]);
        if (sb.errors == 0 && sb.owed_outcomes.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
